// ===== src/wcns_pkg.sv =====
// wcns_pkg: shared types, constants and the weight table of the weighted codebook search
// used by wcns_seq, wcns_mac and weighted_codebook_nearest_search_top; no dependencies
package wcns_pkg;

  localparam int VALUE_BITS     = 20;
  localparam int DIST_BITS      = 50;
  localparam int ENTRY_FLD_BITS = 5;
  localparam int COEFF_FLD_BITS = 4;
  localparam int WEIGHT_BITS    = 6;
  localparam int CFG_BITS       = 6;
  localparam int IN_DATA_BITS   = 32;
  localparam int OUT_DATA_BITS  = 56;

  localparam int DEF_ENTRIES = 32;
  localparam int DEF_COEFFS  = 12;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 6'd32;

  localparam logic FUNC_CODEBOOK = 1'b0;
  localparam logic FUNC_FEATURE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } wcns_state_t;

  // one multiply-accumulate step handed from the sequencer to the datapath
  typedef struct packed {
    logic                   valid;
    logic                   first_coeff;
    logic                   last_coeff;
    logic                   first_entry;
    logic                   last_entry;
    logic [WEIGHT_BITS-1:0] weight;
  } wcns_beat_t;

  function automatic logic [WEIGHT_BITS-1:0] weight_at(input logic [COEFF_FLD_BITS-1:0] idx);
    logic [WEIGHT_BITS-1:0] w;
    case (idx)
      4'd0:    w = 6'd1;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd7;
      4'd3:    w = 6'd13;
      4'd4:    w = 6'd19;
      4'd5:    w = 6'd22;
      4'd6:    w = 6'd25;
      4'd7:    w = 6'd33;
      4'd8:    w = 6'd42;
      4'd9:    w = 6'd50;
      4'd10:   w = 6'd56;
      default: w = 6'd61;
    endcase
    return w;
  endfunction

endpackage

// ===== src/wcns_mac.sv =====
// wcns_mac: shared difference, square, weight and accumulate unit with best-entry tracking
// depends on wcns_pkg; fed one step a cycle by wcns_seq
module wcns_mac #(
  parameter int ENTRIES = wcns_pkg::DEF_ENTRIES,
  parameter int EW      = $clog2(ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wcns_pkg::wcns_beat_t            beat_i,
  input  logic [EW-1:0]                   entry_i,
  input  logic [wcns_pkg::VALUE_BITS-1:0] feat_i,
  input  logic [wcns_pkg::VALUE_BITS-1:0] code_i,
  output logic                            done_o,
  output logic [EW-1:0]                   best_entry_o,
  output logic [wcns_pkg::DIST_BITS-1:0]  best_dist_o
);
  import wcns_pkg::*;

  localparam int SQW = 2 * VALUE_BITS + 1;
  localparam int TW  = SQW + WEIGHT_BITS;

  wcns_beat_t s1_r, s2_r, s3_r;
  logic [EW-1:0] e1_r, e2_r, e3_r;

  logic signed [VALUE_BITS:0]     diff;
  logic signed [2*VALUE_BITS+1:0] prod;
  logic [SQW-1:0]                 sq_r;
  logic [TW-1:0]                  term_full;
  logic [DIST_BITS-1:0]           term_r;
  logic [DIST_BITS-1:0]           acc_r, acc_nxt;
  logic [DIST_BITS-1:0]           best_dist_r;
  logic [EW-1:0]                  best_entry_r;
  logic                           done_r;
  logic                           take;

  always_comb begin
    diff      = $signed({feat_i[VALUE_BITS-1], feat_i}) - $signed({code_i[VALUE_BITS-1], code_i});
    prod      = diff * diff;
    term_full = TW'(sq_r) * TW'(s2_r.weight);
    acc_nxt   = s3_r.first_coeff ? term_r : acc_r + term_r;
    take      = s3_r.valid && s3_r.last_coeff && (s3_r.first_entry || (acc_nxt < best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      s3_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= beat_i;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r.valid && s3_r.last_coeff && s3_r.last_entry;
    end
  end

  always_ff @(posedge clk) begin
    e1_r   <= entry_i;
    e2_r   <= e1_r;
    e3_r   <= e2_r;
    sq_r   <= prod[SQW-1:0];
    term_r <= DIST_BITS'(term_full);
    if (s3_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (take) begin
      best_dist_r  <= acc_nxt;
      best_entry_r <= e3_r;
    end
  end

  assign done_o       = done_r;
  assign best_entry_o = best_entry_r;
  assign best_dist_o  = best_dist_r;

  a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.valid && s3_r.last_coeff && s3_r.last_entry) |=> done_r)
    else $error("search end not flagged");
  a_first_entry_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.valid && s3_r.last_coeff && s3_r.first_entry) |=> (best_entry_r == $past(e3_r)))
    else $error("entry zero not loaded as best");
  a_best_not_worse: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.valid && s3_r.last_coeff && !s3_r.first_entry) |=> (best_dist_r <= $past(best_dist_r)))
    else $error("best distance grew");

endmodule

// ===== src/wcns_seq.sv =====
// wcns_seq: search sequencer that walks entries and coefficients and steps the shared unit
// depends on wcns_pkg; drives wcns_mac and the codebook read port in the top level
module wcns_seq #(
  parameter int ENTRIES = wcns_pkg::DEF_ENTRIES,
  parameter int COEFFS  = wcns_pkg::DEF_COEFFS,
  parameter int EW      = $clog2(ENTRIES),
  parameter int CIW     = (COEFFS > 1) ? $clog2(COEFFS) : 1,
  parameter int AW      = $clog2(ENTRIES * COEFFS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [wcns_pkg::CFG_BITS-1:0] entries_in_use_i,
  input  logic                          done_i,
  input  logic                          out_free_i,
  output logic                          in_ready_o,
  output logic                          load_o,
  output wcns_pkg::wcns_beat_t          beat_o,
  output logic [EW-1:0]                 entry_o,
  output logic [CIW-1:0]                coeff_o,
  output logic [AW-1:0]                 addr_o
);
  import wcns_pkg::*;

  localparam int CW = (CFG_BITS > EW + 1) ? CFG_BITS : EW + 1;

  wcns_state_t   state_r, state_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic [EW-1:0]  last_e_r, last_e_nxt;
  logic [CIW-1:0] i_r, i_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]  cfg_ext;
  logic           coeff_end, entry_end;
  logic           beat_en;

  assign cfg_ext   = CW'(entries_in_use_i);
  assign coeff_end = (i_r == CIW'(COEFFS - 1));
  assign entry_end = (e_r == last_e_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_i) state_nxt = ST_RUN;
      ST_RUN:   if (coeff_end && entry_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (done_i) state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free_i) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    beat_en    = 1'b0;
    load_o     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_RUN:   beat_en    = 1'b1;
      ST_DRAIN: ;
      ST_HOLD:  load_o     = out_free_i;
      default:  ;
    endcase
  end

  // counters
  always_comb begin
    e_nxt      = e_r;
    i_nxt      = i_r;
    addr_nxt   = addr_r;
    last_e_nxt = last_e_r;
    if (state_r == ST_IDLE && start_i) begin
      e_nxt    = '0;
      i_nxt    = '0;
      addr_nxt = '0;
      if (cfg_ext == '0) begin
        last_e_nxt = '0;
      end else if (cfg_ext > CW'(ENTRIES)) begin
        last_e_nxt = EW'(ENTRIES - 1);
      end else begin
        last_e_nxt = EW'(cfg_ext - CW'(1));
      end
    end else if (beat_en) begin
      addr_nxt = addr_r + AW'(1);
      if (coeff_end) begin
        i_nxt = '0;
        e_nxt = e_r + EW'(1);
      end else begin
        i_nxt = i_r + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      e_r      <= '0;
      i_r      <= '0;
      addr_r   <= '0;
      last_e_r <= '0;
    end else begin
      state_r  <= state_nxt;
      e_r      <= e_nxt;
      i_r      <= i_nxt;
      addr_r   <= addr_nxt;
      last_e_r <= last_e_nxt;
    end
  end

  always_comb begin
    beat_o.valid       = beat_en;
    beat_o.first_coeff = (i_r == '0);
    beat_o.last_coeff  = coeff_end;
    beat_o.first_entry = (e_r == '0);
    beat_o.last_entry  = entry_end;
    beat_o.weight      = weight_at(COEFF_FLD_BITS'(i_r));
  end

  assign entry_o = e_r;
  assign coeff_o = i_r;
  assign addr_o  = addr_r;

  a_addr_tracks_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && i_r == '0) |-> (32'(addr_r) == 32'(e_r) * 32'(COEFFS)))
    else $error("read address out of step with entry counter");
  a_run_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && coeff_end && entry_end) |=> (state_r == ST_DRAIN))
    else $error("sweep did not stop after last entry");
  a_done_only_draining: assert property (@(posedge clk) disable iff (!rst_n)
    done_i |-> (state_r == ST_DRAIN))
    else $error("search end seen outside drain");

endmodule

// ===== src/weighted_codebook_nearest_search_top.sv =====
// weighted_codebook_nearest_search_top: top level with codebook memory, feature buffer,
// entry-count register and output register; depends on wcns_pkg, wcns_seq and wcns_mac
//
// usage
//   in_* carries requests. in_tuser = 0 writes one codebook coefficient at
//   (entry_index, coeff_index); in_tuser = 1 stores one feature coefficient, and
//   with in_tlast set it starts a search over entries 0 .. entries_in_use-1.
//   out_* carries one result per search: nearest entry and its weighted
//   squared distance (unsigned integer), lowest index on a tie.
//   cfg_we/cfg_wdata set entries_in_use (0 acts as 1, above ENTRIES as ENTRIES).
// timing
//   every request that does not start a search leaves in_tready high. A search runs
//   one multiply-accumulate per cycle through the single shared unit, so it
//   holds in_tready low until its result has been loaded into the output
//   register; the one codebook read port and that unit serve one search at a time.
//   the result sits in an output register; while it waits, new requests are
//   taken, and only a finished second search waits for the slot to clear.
// reset
//   rst_n (synchronous, active low) idles the sequencer, empties the output and
//   sets entries_in_use to 32. Codebook and feature contents are not cleared.
module weighted_codebook_nearest_search_top #(
  parameter int ENTRIES = wcns_pkg::DEF_ENTRIES,
  parameter int COEFFS  = wcns_pkg::DEF_COEFFS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_index [4:0], coeff_index [8:5], coeff_value [28:9], zero [31:29]
  input  logic [wcns_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // func [0]
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // best_entry [4:0], best_distance [54:5], zero [55]
  output logic [wcns_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                               cfg_we,
  input  logic [wcns_pkg::CFG_BITS-1:0]      cfg_wdata
);
  import wcns_pkg::*;

  localparam int DEPTH = ENTRIES * COEFFS;
  localparam int EW    = $clog2(ENTRIES);
  localparam int CIW   = (COEFFS > 1) ? $clog2(COEFFS) : 1;
  localparam int AW    = $clog2(DEPTH);

  logic [ENTRY_FLD_BITS-1:0] in_entry;
  logic [COEFF_FLD_BITS-1:0] in_coeff;
  logic [VALUE_BITS-1:0]     in_value;
  logic                      in_acc;
  logic                      cb_we, fb_we, start;
  logic [AW-1:0]             wr_addr;

  logic [CFG_BITS-1:0]       entries_in_use_r;
  logic [VALUE_BITS-1:0]     cb_mem [DEPTH];
  logic [VALUE_BITS-1:0]     fb_r   [COEFFS];
  logic [VALUE_BITS-1:0]     cb_q_r, fb_q_r;

  wcns_beat_t                beat;
  logic [EW-1:0]             seq_entry;
  logic [CIW-1:0]            seq_coeff;
  logic [AW-1:0]             rd_addr;
  logic                      done, load, out_free;
  logic [EW-1:0]             best_entry;
  logic [DIST_BITS-1:0]      best_dist;

  logic                      out_valid_r;
  logic [OUT_DATA_BITS-1:0]  out_data_r;

  assign in_entry = in_tdata[ENTRY_FLD_BITS-1:0];
  assign in_coeff = in_tdata[ENTRY_FLD_BITS +: COEFF_FLD_BITS];
  assign in_value = in_tdata[ENTRY_FLD_BITS + COEFF_FLD_BITS +: VALUE_BITS];
  assign in_acc   = in_tvalid && in_tready;

  assign cb_we   = in_acc && (in_tuser == FUNC_CODEBOOK)
                   && (32'(in_entry) < 32'(ENTRIES)) && (32'(in_coeff) < 32'(COEFFS));
  assign fb_we   = in_acc && (in_tuser == FUNC_FEATURE) && (32'(in_coeff) < 32'(COEFFS));
  assign start   = in_acc && (in_tuser == FUNC_FEATURE) && in_tlast;
  assign wr_addr = AW'(32'(in_entry) * 32'(COEFFS) + 32'(in_coeff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      entries_in_use_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[wr_addr] <= in_value;
    end
    if (beat.valid) begin
      cb_q_r <= cb_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_r[CIW'(in_coeff)] <= in_value;
    end
    if (beat.valid) begin
      fb_q_r <= fb_r[seq_coeff];
    end
  end

  wcns_seq #(
    .ENTRIES (ENTRIES),
    .COEFFS  (COEFFS),
    .EW      (EW),
    .CIW     (CIW),
    .AW      (AW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start_i          (start),
    .entries_in_use_i (entries_in_use_r),
    .done_i           (done),
    .out_free_i       (out_free),
    .in_ready_o       (in_tready),
    .load_o           (load),
    .beat_o           (beat),
    .entry_o          (seq_entry),
    .coeff_o          (seq_coeff),
    .addr_o           (rd_addr)
  );

  wcns_mac #(
    .ENTRIES (ENTRIES),
    .EW      (EW)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_i       (beat),
    .entry_i      (seq_entry),
    .feat_i       (fb_q_r),
    .code_i       (cb_q_r),
    .done_o       (done),
    .best_entry_o (best_entry),
    .best_dist_o  (best_dist)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {1'b0, best_dist, ENTRY_FLD_BITS'(best_entry)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_valid_r) |-> out_tready)
    else $error("pending result overwritten");
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("request taken during search");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("result lost at output register");

endmodule
